[sv/triangular_fuzzy_domination_compare_top_defines.svh]
// assertion macros for the comparator modules, used by tfd_scale
// no dependencies
`ifndef TRIANGULAR_FUZZY_DOMINATION_COMPARE_TOP_DEFINES_SVH
`define TRIANGULAR_FUZZY_DOMINATION_COMPARE_TOP_DEFINES_SVH

// implication checked every clock outside reset
`define TFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define TFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/tfd_pkg.sv]
// shared widths and constants for the fuzzy domination comparator
// no dependencies
package tfd_pkg;
  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int ID_BITS    = 32;
  localparam int OUT_BITS   = 51;
  localparam int SUM_BITS   = VALUE_BITS + 2;
  localparam int HALF_SHIFT = FRAC_BITS - 1;
  localparam logic [OUT_BITS-1:0] POS_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] NEG_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};
  localparam logic [OUT_BITS-1:0] POS_LIM = POS_MAX >> HALF_SHIFT;
  localparam logic [OUT_BITS-1:0] NEG_LIM = NEG_MIN >> HALF_SHIFT;

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [SUM_BITS-1:0]   sum_t;
  typedef logic [ID_BITS-1:0]    id_t;
  typedef logic [OUT_BITS-1:0]   dom_t;
endpackage

[sv/tfd_weight.sv]
// stage 1: order check and triangle weights low + 2*peak + high
// uses tfd_pkg
module tfd_weight import tfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  val_t al, ap, ah, bl, bp, bh,
  input  id_t  aid, bid,
  output logic valid,
  output sum_t wa, wb,
  output id_t  aid_q, bid_q,
  output logic err
);
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
    if (en) begin
      wa    <= SUM_BITS'(al) + {1'b0, ap, 1'b0} + SUM_BITS'(ah);
      wb    <= SUM_BITS'(bl) + {1'b0, bp, 1'b0} + SUM_BITS'(bh);
      aid_q <= aid;
      bid_q <= bid;
      err   <= (al > ap) || (ap > ah) || (bl > bp) || (bp > bh);
    end
  end
endmodule

[sv/tfd_diff.sv]
// stage 2: magnitude of the weight difference, which weight is larger, and the id comparison
// uses tfd_pkg
module tfd_diff import tfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  sum_t wa, wb,
  input  id_t  aid, bid,
  input  logic err_in,
  output logic valid,
  output sum_t mag,
  output logic a_ge,
  output logic id_gt,
  output logic err
);
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
    if (en) begin
      a_ge  <= wa >= wb;
      mag   <= (wa >= wb) ? wa - wb : wb - wa;
      id_gt <= bid > aid;
      err   <= err_in;
    end
  end
endmodule

[sv/tfd_scale.sv]
// stage 3: scale, saturate, sign and verdict into the output register
// uses tfd_pkg and the assertion macro header
`include "triangular_fuzzy_domination_compare_top_defines.svh"
module tfd_scale import tfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  sum_t mag,
  input  logic a_ge,
  input  logic id_gt,
  input  logic err_in,
  output logic valid,
  output dom_t dab,
  output dom_t dba,
  output logic less,
  output logic err
);
  dom_t m, pos_v, neg_v;
  logic zero, a_dom, b_dom, verdict;

  always_comb begin
    m       = OUT_BITS'(mag);
    zero    = (mag == '0);
    pos_v   = (m > POS_LIM) ? POS_MAX : (m << HALF_SHIFT);
    neg_v   = (m > NEG_LIM) ? NEG_MIN : (dom_t'(0) - (m << HALF_SHIFT));
    a_dom   = a_ge && !zero;
    b_dom   = !a_ge;
    // mutual domination goes to b when its id is larger; a_dom and b_dom never hold together
    verdict = (a_dom && b_dom) ? id_gt : b_dom;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
    if (en) begin
      err <= err_in;
      if (err_in) begin
        dab  <= '0;
        dba  <= '0;
        less <= 1'b0;
      end else if (zero) begin
        // equal weights: neither side dominates
        dab  <= '0;
        dba  <= '0;
        less <= 1'b0;
      end else if (a_ge) begin
        dab  <= pos_v;
        dba  <= neg_v;
        less <= verdict;
      end else begin
        dab  <= neg_v;
        dba  <= pos_v;
        less <= verdict;
      end
    end
  end

  `TFD_ASSERT_IMP(err_clears, valid && err, dab == '0 && dba == '0 && !less, "error item not zero")
  `TFD_ASSERT_IMP(antisym, valid && !err, (dab == '0) == (dba == '0), "domination not antisymmetric")
  `TFD_ASSERT_NEXT(hold_out, valid && !en, $stable(dab) && $stable(less) && valid, "stalled result moved")
endmodule

[sv/triangular_fuzzy_domination_compare_top.sv]
// Triangular fuzzy number domination comparator. One pair of triangles
// (low, peak, high) with ids enters per cycle; each result passes through
// a three-stage pipeline (weights, differences, scaling and verdict).
// Dominations are signed with 31 fraction bits; out-of-order points set
// order_error and zero the other fields. A stall freezes the whole
// pipeline, so the rate is one item per cycle while the output side
// takes items.
// uses tfd_pkg, tfd_weight, tfd_diff, tfd_scale
module triangular_fuzzy_domination_compare_top import tfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  val_t a_low, a_peak, a_high,
  input  val_t b_low, b_peak, b_high,
  input  id_t  a_id, b_id,
  output logic out_valid,
  input  logic out_stall,
  output dom_t dom_a_over_b,
  output dom_t dom_b_over_a,
  output logic a_less_than_b,
  output logic order_error
);
  logic en;
  logic v1, v2, e1, e2, age, idg;
  sum_t wa, wb, mag;
  id_t  aid1, bid1;

  // whole pipeline advances unless a finished item is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  tfd_weight u_w (.clk, .rst, .en, .in_valid,
    .al(a_low), .ap(a_peak), .ah(a_high), .bl(b_low), .bp(b_peak), .bh(b_high),
    .aid(a_id), .bid(b_id), .valid(v1), .wa, .wb, .aid_q(aid1), .bid_q(bid1), .err(e1));

  tfd_diff u_d (.clk, .rst, .en, .in_valid(v1), .wa, .wb, .aid(aid1), .bid(bid1),
    .err_in(e1), .valid(v2), .mag, .a_ge(age), .id_gt(idg), .err(e2));

  tfd_scale u_s (.clk, .rst, .en, .in_valid(v2), .mag, .a_ge(age), .id_gt(idg),
    .err_in(e2), .valid(out_valid), .dab(dom_a_over_b), .dba(dom_b_over_a),
    .less(a_less_than_b), .err(order_error));
endmodule
